// ----- rtl/bspc_pkg.sv -----
// shared types and constants for the bounded stack with palindrome check
`timescale 1ns / 1ps
`default_nettype none
package bspc_pkg;

  localparam int OP_W        = 2;
  localparam int WORD_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (STATUS_W + WORD_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PAL  = 2'd2,
    OP_SHOW = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // latch the incoming beat, set up read pointers
    logic emit_simple;  // push, pop or empty answer
    logic emit_pal;     // palindrome verdict
    logic emit_show;    // one displayed element
    logic step_pal;     // move both pointers inward
    logic step_show;    // move top pointer down
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic out_free;
    logic pal_done;
    logic show_last;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/bounded_stack_with_palindrome_check.sv -----
// top level of the bounded stack with palindrome check
//
//  channel | dir | tdata fields, lowest bit up                 | tlast
//  s_*     | in  | operation[1:0], push_value[33:2], zero pad   | -
//  m_*     | out | status[1:0], data_out[33:2], is_palindrome[34], zero pad | last
//
// push, pop and any empty answer go through accept, ram read and execute before the
// next accept; the registered read of the entry ram is what needs the ram read state.
// palindrome check: a ram read and a compare for each pair of entries, until a
// mismatch or the pointers meet; display of the entries: one ram read and one beat
// per entry.
// reset clears the fill count, the state machine and the output valid; the
// entry ram is not cleared, only entries below the fill count are ever read.
// a stalled output holds its beat; the block keeps working until the next
// beat must be loaded, and takes a new input beat while a result still waits.
`timescale 1ns / 1ps
`default_nettype none
module bounded_stack_with_palindrome_check
  import bspc_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input beats
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // operation, push_value, pad
  // result beats
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // status, data_out, is_palindrome, pad
  output logic                        m_tlast
);

  cmd_t cmd;
  sts_t sts;

  // unpack the input beat
  op_t                      in_op;
  logic signed [WORD_W-1:0] in_val;

  assign in_op  = op_t'(s_tdata[OP_W-1:0]);
  assign in_val = s_tdata[OP_W +: WORD_W];

  bspc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bspc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_op     (in_op),
    .in_val    (in_val),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/bspc_ram.sv -----
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module bspc_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr_a,
  input  wire logic [AW-1:0]        raddr_b,
  output logic      [WIDTH-1:0]     rdata_a,
  output logic      [WIDTH-1:0]     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ----- rtl/bspc_ctrl.sv -----
// sequencing state machine for the stack
`timescale 1ns / 1ps
`default_nettype none
module bspc_ctrl
  import bspc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_PCMP = 5'b01000,
    S_SHOW = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      // ram data for the pointers shows up after this cycle
      S_READ: begin
        if (sts.empty || sts.op == OP_PUSH || sts.op == OP_POP) begin
          state_next = S_EXEC;
        end else if (sts.op == OP_PAL) begin
          state_next = S_PCMP;
        end else begin
          state_next = S_SHOW;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.emit_simple = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_PCMP: begin
        if (!sts.pal_done) begin
          cmd.step_pal = 1'b1;
          state_next   = S_READ;
        end else if (sts.out_free) begin
          cmd.emit_pal = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SHOW: begin
        if (sts.out_free) begin
          cmd.emit_show = 1'b1;
          if (sts.show_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step_show = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/bspc_dp.sv -----
// stack datapath: fill count, pointers, entry ram and output register
`timescale 1ns / 1ps
`default_nettype none
module bspc_dp
  import bspc_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire op_t                     in_op,
  input  wire logic signed [WORD_W-1:0] in_val,
  input  wire cmd_t                    cmd,
  output sts_t                         sts,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [OUT_TDATA_W-1:0]       out_data,
  output logic                         out_last
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_m1;
  op_t                      op_q;
  logic signed [WORD_W-1:0] val_q;
  logic [AW-1:0]            ptr_lo;
  logic [AW-1:0]            ptr_hi;
  logic [WORD_W-1:0]        rd_lo;
  logic [WORD_W-1:0]        rd_hi;
  logic                     full;
  logic                     empty;
  logic                     out_free;
  logic                     ram_we;

  status_t                  o_status;
  logic [WORD_W-1:0]        o_data;
  logic                     o_pal;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign count_m1 = count - CW'(1);
  assign out_free = !out_valid || out_ready;
  assign ram_we   = cmd.emit_simple && (op_q == OP_PUSH) && !full;

  assign sts.op        = op_q;
  assign sts.empty     = empty;
  assign sts.out_free  = out_free;
  assign sts.pal_done  = !(ptr_lo < ptr_hi) || (rd_lo != rd_hi);
  assign sts.show_last = (ptr_hi == '0);

  bspc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (count[AW-1:0]),
    .wdata   (val_q),
    .raddr_a (ptr_lo),
    .raddr_b (ptr_hi),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  // beat latch and pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_op;
      val_q  <= in_val;
      ptr_lo <= '0;
      ptr_hi <= count_m1[AW-1:0];
    end else begin
      if (cmd.step_pal) begin
        ptr_lo <= ptr_lo + AW'(1);
        ptr_hi <= ptr_hi - AW'(1);
      end
      if (cmd.step_show) begin
        ptr_hi <= ptr_hi - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.emit_simple) begin
      if (op_q == OP_PUSH && !full) begin
        count <= count + CW'(1);
      end else if (op_q == OP_POP && !empty) begin
        count <= count_m1;
      end
    end
  end

  // result fields
  always_comb begin
    o_status = ST_OK;
    o_data   = '0;
    o_pal    = 1'b0;
    if (cmd.emit_simple) begin
      case (op_q)
        OP_PUSH: o_status = full ? ST_OVER : ST_OK;
        OP_POP: begin
          if (empty) begin
            o_status = ST_EMPTY;
          end else begin
            o_data = rd_hi;
          end
        end
        default: o_status = ST_EMPTY;
      endcase
    end else if (cmd.emit_pal) begin
      o_pal = !(ptr_lo < ptr_hi);
    end else if (cmd.emit_show) begin
      o_data = rd_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_simple || cmd.emit_pal || cmd.emit_show) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_simple || cmd.emit_pal || cmd.emit_show) begin
      out_data <= {{OUT_PAD_W{1'b0}}, o_pal, o_data, o_status};
      out_last <= cmd.emit_simple || cmd.emit_pal || sts.show_last;
    end
  end

endmodule
`default_nettype wire
